// File: hdl/isf_pkg.sv
package isf_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_STRENGTH = 3'd3;
  localparam logic [2:0] REG_MIN_DIST = 3'd4;
  localparam logic [2:0] REG_REPEL    = 3'd5;
  localparam logic [2:0] REG_ENABLE   = 3'd6;

  localparam logic [30:0] MIN_DIST_RESET = 31'd6554;

  // square root: 35 result bits, radicand up to 3*2^64; the width leaves room
  // for the top trial value 2^68 so the unused top root bit never sets
  localparam int SQRT_BITS = 35;
  localparam int SUMSQ_W   = 70;
  // r^3 is up to 105 bits; numerator 32+33+FRAC_BITS bits, 89 bits for FRAC_BITS up to 24
  localparam int CUBE_W    = 105;
  localparam int NUM_W     = 89;
  localparam int QUO_W     = 34;

endpackage

// File: hdl/isf_sqrt_cell.sv
// One restoring square-root step; each cell resolves one result bit.
module isf_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [isf_pkg::SUMSQ_W-1:0]            rem_in,
  input  logic [isf_pkg::SQRT_BITS-1:0]          root_in,
  output logic [isf_pkg::SUMSQ_W-1:0]            rem_out,
  output logic [isf_pkg::SQRT_BITS-1:0]          root_out
);
  logic [isf_pkg::SUMSQ_W-1:0] trial;
  logic [isf_pkg::SUMSQ_W-1:0] root_w;

  // trial = (2*root + 2^BIT) * 2^BIT = (root<<(BIT+1)) | (1<<(2*BIT))
  always_comb begin
    root_w = isf_pkg::SUMSQ_W'(root_in);
    trial  = (root_w << (BIT + 1)) | (isf_pkg::SUMSQ_W'(1) << (2 * BIT));
  end

  // step only when the chain advances
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= root_in | (isf_pkg::SQRT_BITS'(1) << BIT);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule

// File: hdl/isf_div_cell.sv
// One restoring divide step for three lanes sharing a divisor.
module isf_div_cell #(
  parameter int BIT = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [isf_pkg::CUBE_W-1:0]      den,
  input  logic [isf_pkg::NUM_W-1:0]       rem_in  [3],
  input  logic [isf_pkg::QUO_W-1:0]       quo_in  [3],
  output logic [isf_pkg::NUM_W-1:0]       rem_out [3],
  output logic [isf_pkg::QUO_W-1:0]       quo_out [3]
);
  localparam int SW = isf_pkg::CUBE_W + BIT;
  logic [SW-1:0] dsh;
  logic          fit [3];

  // quotient bit BIT set when rem >= den * 2^BIT; while the quotient fits
  // QUO_W bits, remainders stay below den * 2^(BIT+1)
  always_comb begin
    dsh = SW'(den) << BIT;
    for (int l = 0; l < 3; l++) fit[l] = SW'(rem_in[l]) >= dsh;
  end

  // step only when the chain advances
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (fit[l]) begin
          rem_out[l] <= isf_pkg::NUM_W'(SW'(rem_in[l]) - dsh);
          quo_out[l] <= quo_in[l] | (isf_pkg::QUO_W'(1) << BIT);
        end else begin
          rem_out[l] <= rem_in[l];
          quo_out[l] <= quo_in[l];
        end
      end
    end
  end
endmodule

// File: hdl/inverse_square_point_force.sv
// Pipeline: offsets, sum of squares, square-root cells, clamp, r^2, r^3 halves,
// r^3, divide cells, final add and saturate.
// Throughput: one particle per cycle while not stalled; the square-root and divide
// cell rows set the latency and hold one particle per cell.
// Stalls freeze the whole pipeline; a valid-bit per stage tracks occupancy.
// Reset (rst, synchronous) clears valid bits and loads register reset values.
module inverse_square_point_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, accel_in_x, accel_in_y, accel_in_z (32 bits each)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accel_out_x, accel_out_y, accel_out_z (32 bits each)
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);
  localparam int SB = isf_pkg::SQRT_BITS;
  localparam int SQ = isf_pkg::SUMSQ_W;
  localparam int CW = isf_pkg::CUBE_W;
  localparam int NW = isf_pkg::NUM_W;
  localparam int QW = isf_pkg::QUO_W;
  localparam int OW = CW + QW;
  localparam int NSTG = 2 + SB + 4 + QW + 1;

  // configuration registers
  logic signed [31:0] center [3];
  logic signed [31:0] strength;
  logic [30:0]        min_distance;
  logic               repel_mode, enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) center[i] <= '0;
      strength <= '0; min_distance <= isf_pkg::MIN_DIST_RESET;
      repel_mode <= 1'b0; enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        isf_pkg::REG_CENTER_X: center[0] <= cfg_data;
        isf_pkg::REG_CENTER_Y: center[1] <= cfg_data;
        isf_pkg::REG_CENTER_Z: center[2] <= cfg_data;
        isf_pkg::REG_STRENGTH: strength <= cfg_data;
        isf_pkg::REG_MIN_DIST: min_distance <= cfg_data[30:0];
        isf_pkg::REG_REPEL:    repel_mode <= cfg_data[0];
        isf_pkg::REG_ENABLE:   enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advance: whole chain moves when output is free
  logic adv;
  logic [NSTG-1:0] vld;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NSTG-2:0], s_axis_tvalid};
  end

  // per-item payload carried alongside: acc, |d|, sign of k*d
  typedef struct packed {
    logic [2:0][31:0] acc;
    logic [2:0][32:0] dmag;
    logic [2:0]       neg;
  } carry_t;

  carry_t cr [1:NSTG-2];

  // stage 0: offsets
  logic signed [32:0] d0 [3];
  logic [2:0][31:0]   acc0;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (repel_mode)
          d0[i] <= 33'(signed'(s_axis_tdata[32*i +: 32])) - 33'(center[i]);
        else
          d0[i] <= 33'(center[i]) - 33'(signed'(s_axis_tdata[32*i +: 32]));
        acc0[i] <= s_axis_tdata[96 + 32*i +: 32];
      end
    end
  end

  // stage 1: magnitudes, squares, sum; payload shift for later stages
  logic [32:0] dm [3];
  always_comb
    for (int i = 0; i < 3; i++) dm[i] = d0[i][32] ? 33'(-d0[i]) : 33'(d0[i]);

  logic [SQ-1:0] sumsq;
  always_ff @(posedge clk) begin
    if (adv) begin
      sumsq <= SQ'(66'(dm[0]) * 66'(dm[0])) + SQ'(66'(dm[1]) * 66'(dm[1]))
             + SQ'(66'(dm[2]) * 66'(dm[2]));
      cr[1].acc <= acc0;
      for (int i = 0; i < 3; i++) begin
        cr[1].dmag[i] <= dm[i];
        cr[1].neg[i]  <= strength[31] != d0[i][32];
      end
      for (int s = 2; s < NSTG - 1; s++) cr[s] <= cr[s-1];
    end
  end

  // square-root cell row; cells hold while stalled
  logic [SQ-1:0] srem  [SB+1];
  logic [SB-1:0] sroot [SB+1];
  assign srem[0]  = sumsq;
  assign sroot[0] = '0;

  for (genvar c = 0; c < SB; c++) begin : g_sqrt
    isf_sqrt_cell #(.BIT(SB-1-c)) u_cell (
      .clk(clk), .en(adv), .rem_in(srem[c]), .root_in(sroot[c]),
      .rem_out(srem[c+1]), .root_out(sroot[c+1])
    );
  end

  // numerators |k|*|d|*2^FRAC_BITS
  logic [31:0] kmag;
  assign kmag = strength[31] ? 32'(-strength) : 32'(strength);

  // clamp, r^2, r^3 as two partial products of the 35-bit halves of r^2, then their sum
  localparam int SD = 2 + SB + 2;
  logic [SB-1:0]   rcl;
  logic [2*SB-1:0] r2;
  logic [SB-1:0]   rcl2;
  logic [2*SB-1:0] plo, phi;
  logic [CW-1:0]   r3;
  logic            rz2, rz3, rz4;
  logic [NW-1:0]   num [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      rcl  <= (sroot[SB] < SB'(min_distance)) ? SB'(min_distance) : sroot[SB];
      r2   <= (2*SB)'(rcl) * (2*SB)'(rcl);
      rcl2 <= rcl;
      rz2  <= rcl == '0;
      plo  <= (2*SB)'(r2[SB-1:0]) * (2*SB)'(rcl2);
      phi  <= (2*SB)'(r2[2*SB-1:SB]) * (2*SB)'(rcl2);
      rz3  <= rz2;
      r3   <= CW'(plo) + (CW'(phi) << SB);
      rz4  <= rz3;
      for (int i = 0; i < 3; i++)
        num[i] <= NW'(65'(kmag) * 65'(cr[SD].dmag[i])) << FRAC_BITS;
    end
  end

  // divide cell row; a quotient too large for QW bits is flagged up front
  logic [NW-1:0] drem [QW+1][3];
  logic [QW-1:0] dquo [QW+1][3];
  logic [CW-1:0] dden [QW+1];
  logic          dz   [QW+1];
  logic [2:0]    dovf [QW+1];
  assign drem[0] = num;
  assign dquo[0] = '{'0, '0, '0};
  assign dden[0] = r3;
  assign dz[0]   = rz4;
  assign dovf[0] = {OW'(num[2]) >= {r3, QW'(0)}, OW'(num[1]) >= {r3, QW'(0)},
                    OW'(num[0]) >= {r3, QW'(0)}};

  for (genvar c = 0; c < QW; c++) begin : g_div
    isf_div_cell #(.BIT(QW-1-c)) u_cell (
      .clk(clk), .en(adv), .den(dden[c]), .rem_in(drem[c]), .quo_in(dquo[c]),
      .rem_out(drem[c+1]), .quo_out(dquo[c+1])
    );
    always_ff @(posedge clk)
      if (adv) begin dden[c+1] <= dden[c]; dz[c+1] <= dz[c]; dovf[c+1] <= dovf[c]; end
  end

  // final add and saturate; acc passes unchanged when disabled or r is zero
  logic [QW-1:0] qcap [3];
  logic signed [35:0] sum [3];
  logic [2:0] sat;
  carry_t cf;
  assign cf = cr[NSTG-2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dovf[QW][i] || (dquo[QW][i] > (QW'(1) << 33))) qcap[i] = QW'(1) << 33;
      else qcap[i] = dquo[QW][i];
      sum[i]  = 36'(signed'(cf.acc[i])) +
                (cf.neg[i] ? -36'({2'b0, qcap[i]}) : 36'({2'b0, qcap[i]}));
      sat[i]  = (sum[i] > 36'sh7FFFFFFF) || (sum[i] < -36'sh80000000);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (!enable || dz[QW])
          m_axis_tdata[32*i +: 32] <= cf.acc[i];
        else if (sat[i])
          m_axis_tdata[32*i +: 32] <= sum[i][35] ? 32'h80000000 : 32'h7FFFFFFF;
        else
          m_axis_tdata[32*i +: 32] <= sum[i][31:0];
      end
      m_axis_tuser <= enable && !dz[QW] && (|sat);
    end
  end
endmodule
